>>> hw/rtl/stereo_comb_allpass_reverb_macros.svh
// assertion macros for the stereo comb/allpass reverb
// used by files that carry concurrent checks; no other dependencies
`ifndef STEREO_COMB_ALLPASS_REVERB_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is high
`define SCAR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scar assertion failed");
// clocked check that also holds across reset
`define SCAR_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scar assertion failed");
`else
`define SCAR_ASSERT(lbl, clk, rst, prop)
`define SCAR_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/scar_pkg.sv
// shared types, constants and helper functions of the stereo reverb
// no dependencies
`timescale 1ns / 1ps
package scar_pkg;

   localparam int COMB_COUNT_DEF         = 8;
   localparam int ALLPASS_COUNT_DEF      = 4;
   localparam int STEREO_SPREAD_DEF      = 23;
   localparam int COMB_MAX_LENGTH_DEF    = 2048;
   localparam int ALLPASS_MAX_LENGTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF        = 16;

   localparam int INPUT_GAIN     = 492;
   localparam int FEEDBACK_RESET = 27525;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic        ENABLE_RESET   = 1'b1;
   localparam logic        MONO_RESET     = 1'b0;
   localparam logic [14:0] DRY_RESET      = 15'd16384;
   localparam logic [14:0] WET_MAIN_RESET = 15'd12288;
   localparam logic [14:0] WET_CROSS_RESET = 15'd0;
   localparam logic [14:0] DAMPING_RESET  = 15'd16384;
   localparam logic [3:0]  FB_INDEX_RESET = 4'd0;
   localparam logic [14:0] FB_VALUE_RESET = 15'd27525;

   typedef enum logic [2:0] {
      REG_ENABLE, REG_MONO, REG_DRY, REG_WET_MAIN,
      REG_WET_CROSS, REG_DAMPING, REG_FB_INDEX, REG_FB_VALUE
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_BYPASS, ST_COMB_RD, ST_COMB_LP, ST_COMB_FB,
      ST_AP_RD, ST_AP_WR, ST_MIX, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_COMB_RD, OP_COMB_LP, OP_COMB_FB,
      OP_AP_RD, OP_AP_WR, OP_MIX, OP_OUT, OP_BYPASS
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic comb_last;
      logic ap_last;
      logic mix_last;
   } status_type;

   localparam int COMB_TUNE [16] = '{
      1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617,
      1687, 1733, 1801, 1867, 1931, 1997, 2053, 2111
   };
   localparam int ALLPASS_TUNE [8] = '{556, 441, 341, 225, 179, 131, 97, 67};

   // comb line length, right side longer by the spread, capped at the max
   function automatic int comb_len(int line, int count, int spread, int maxlen);
      int base;
      int n;
      base = (line >= count) ? line - count : line;
      n = COMB_TUNE[base & 15] + ((line >= count) ? spread : 0);
      return (n > maxlen) ? maxlen : n;
   endfunction

   function automatic int allpass_len(int line, int count, int spread, int maxlen);
      int base;
      int n;
      base = (line >= count) ? line - count : line;
      n = ALLPASS_TUNE[base & 7] + ((line >= count) ? spread : 0);
      return (n > maxlen) ? maxlen : n;
   endfunction

   // clamp to a signed range of the given width
   function automatic logic signed [63:0] sat_to(logic signed [63:0] v, int bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

endpackage

>>> hw/rtl/scar_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
module scar_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
endmodule

>>> hw/rtl/scar_csr.sv
// configuration registers and comb feedback table behind the apb-style port
// depends on scar_pkg
`timescale 1ns / 1ps
module scar_csr #(
   parameter int COMB_COUNT = scar_pkg::COMB_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scar_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [scar_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [scar_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic                                enable,
   output logic                                mono_input,
   output logic [14:0]                         dry_gain,
   output logic [14:0]                         wet_main_gain,
   output logic [14:0]                         wet_cross_gain,
   output logic [14:0]                         damping,
   input  logic [$clog2(2*COMB_COUNT)-1:0]     fb_line,
   output logic [14:0]                         fb_value
);
   import scar_pkg::*;

   localparam int NCL = 2 * COMB_COUNT;
   localparam int CLW = $clog2(NCL);

   logic        enable_ff, mono_ff;
   logic [14:0] dry_ff, wm_ff, wc_ff, damp_ff, fbv_ff;
   logic [3:0]  fbi_ff;
   logic [14:0] fb_tab_ff [NCL];
   logic        wr;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[4:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RESET;
         mono_ff   <= MONO_RESET;
         dry_ff    <= DRY_RESET;
         wm_ff     <= WET_MAIN_RESET;
         wc_ff     <= WET_CROSS_RESET;
         damp_ff   <= DAMPING_RESET;
         fbi_ff    <= FB_INDEX_RESET;
         fbv_ff    <= FB_VALUE_RESET;
         for (int i = 0; i < NCL; i++) begin
            fb_tab_ff[i] <= FB_VALUE_RESET;
         end
      end else if (wr) begin
         unique case (idx)
            REG_ENABLE:    enable_ff <= csr_pwdata[0];
            REG_MONO:      mono_ff   <= csr_pwdata[0];
            REG_DRY:       dry_ff    <= csr_pwdata[14:0];
            REG_WET_MAIN:  wm_ff     <= csr_pwdata[14:0];
            REG_WET_CROSS: wc_ff     <= csr_pwdata[14:0];
            REG_DAMPING:   damp_ff   <= csr_pwdata[14:0];
            REG_FB_INDEX:  fbi_ff    <= csr_pwdata[3:0];
            REG_FB_VALUE: begin
               fbv_ff <= csr_pwdata[14:0];
               if (32'(fbi_ff) < NCL) begin
                  fb_tab_ff[CLW'(fbi_ff)] <= csr_pwdata[14:0];
               end
            end
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_ENABLE:    csr_prdata = 32'(enable_ff);
         REG_MONO:      csr_prdata = 32'(mono_ff);
         REG_DRY:       csr_prdata = 32'(dry_ff);
         REG_WET_MAIN:  csr_prdata = 32'(wm_ff);
         REG_WET_CROSS: csr_prdata = 32'(wc_ff);
         REG_DAMPING:   csr_prdata = 32'(damp_ff);
         REG_FB_INDEX:  csr_prdata = 32'(fbi_ff);
         REG_FB_VALUE:  csr_prdata = 32'(fbv_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign enable         = enable_ff;
   assign mono_input     = mono_ff;
   assign dry_gain       = dry_ff;
   assign wet_main_gain  = wm_ff;
   assign wet_cross_gain = wc_ff;
   assign damping        = damp_ff;
   assign fb_value       = fb_tab_ff[fb_line];
endmodule

>>> hw/rtl/scar_datapath.sv
// reverb datapath: delay memories, comb lowpass, allpass chain and output mix
// depends on scar_pkg and scar_ram
`timescale 1ns / 1ps
module scar_datapath #(
   parameter int COMB_COUNT         = scar_pkg::COMB_COUNT_DEF,
   parameter int ALLPASS_COUNT      = scar_pkg::ALLPASS_COUNT_DEF,
   parameter int STEREO_SPREAD      = scar_pkg::STEREO_SPREAD_DEF,
   parameter int COMB_MAX_LENGTH    = scar_pkg::COMB_MAX_LENGTH_DEF,
   parameter int ALLPASS_MAX_LENGTH = scar_pkg::ALLPASS_MAX_LENGTH_DEF,
   parameter int SAMPLE_BITS        = scar_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  scar_pkg::cmd_type               cmd,
   output scar_pkg::status_type            status,
   input  logic signed [15:0]              left_in,
   input  logic signed [15:0]              right_in,
   input  logic                            mono_input,
   input  logic [14:0]                     dry_gain,
   input  logic [14:0]                     wet_main_gain,
   input  logic [14:0]                     wet_cross_gain,
   input  logic [14:0]                     damping,
   output logic [$clog2(2*COMB_COUNT)-1:0] fb_line,
   input  logic [14:0]                     fb_value,
   output logic signed [15:0]              left_out,
   output logic signed [15:0]              right_out
);
   import scar_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int NCL  = 2 * COMB_COUNT;
   localparam int NAL  = 2 * ALLPASS_COUNT;
   localparam int CLW  = $clog2(NCL);
   localparam int ALW  = $clog2(NAL);
   localparam int CPW  = $clog2(COMB_MAX_LENGTH);
   localparam int APW  = $clog2(ALLPASS_MAX_LENGTH);
   localparam int CPX  = CPW + 1;
   localparam int APX  = APW + 1;
   localparam int CAW  = CLW + CPW;
   localparam int AAW  = ALW + APW;
   localparam int CLRW = (CAW > AAW) ? CAW : AAW;
   localparam int CW   = SB + $clog2(COMB_COUNT + ALLPASS_COUNT) + 1;
   localparam int AW   = (CW > 16) ? CW : 16;
   localparam int MW   = AW + 19;

   // control counters and per-line state
   logic [CLW-1:0]         line_ff;
   logic [ALW-1:0]         ap_line_ff;
   logic [2:0]             mix_ff;
   logic [CLRW:0]          clr_ff;
   logic [CPW-1:0]         cpos_ff [NCL];
   logic [APW-1:0]         apos_ff [NAL];
   logic signed [SB-1:0]   lp_ff [NCL];
   // per-item payload
   logic signed [15:0]     inl_ff, inr_ff;
   logic signed [16:0]     x_ff;
   logic signed [CW-1:0]   sl_ff, sr_ff;
   logic signed [MW-1:0]   acc_ff;
   logic signed [15:0]     ol_ff, or_ff, lo_ff, ro_ff;

   // memory ports
   logic                   c_we, a_we;
   logic [CAW-1:0]         c_waddr, c_raddr;
   logic [AAW-1:0]         a_waddr, a_raddr;
   logic [SB-1:0]          c_wdata, a_wdata, c_rdata, a_rdata;

   scar_ram #(.WIDTH(SB), .DEPTH(2**CAW)) u_comb_ram (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata_ff(c_rdata)
   );

   scar_ram #(.WIDTH(SB), .DEPTH(2**AAW)) u_ap_ram (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata_ff(a_rdata)
   );

   // current line position with wrap
   logic [CPX-1:0]         clen, cpn;
   logic [CPW-1:0]         cp_eff, cp_next;
   logic [APX-1:0]         alen, apn;
   logic [APW-1:0]         ap_eff, ap_next;

   always_comb begin
      clen    = CPX'(comb_len(int'(line_ff), COMB_COUNT, STEREO_SPREAD, COMB_MAX_LENGTH));
      cp_eff  = ({1'b0, cpos_ff[line_ff]} >= clen) ? '0 : cpos_ff[line_ff];
      cpn     = {1'b0, cp_eff} + CPX'(1);
      cp_next = (cpn >= clen) ? '0 : cpn[CPW-1:0];
      alen    = APX'(allpass_len(int'(ap_line_ff), ALLPASS_COUNT, STEREO_SPREAD,
                                 ALLPASS_MAX_LENGTH));
      ap_eff  = ({1'b0, apos_ff[ap_line_ff]} >= alen) ? '0 : apos_ff[ap_line_ff];
      apn     = {1'b0, ap_eff} + APX'(1);
      ap_next = (apn >= alen) ? '0 : apn[APW-1:0];
   end

   // input scaling: round((l + r) * gain / 2^15)
   logic signed [16:0]     in_sum;
   logic signed [15:0]     rsel;
   logic signed [27:0]     x_prod;
   always_comb begin
      rsel   = mono_input ? left_in : right_in;
      in_sum = 17'(left_in) + 17'(rsel);
      x_prod = in_sum * $signed(11'(INPUT_GAIN));
   end

   // comb lowpass: lp = round((out*32768 + (lp - out)*d) / 2^15)
   logic signed [SB-1:0]   c_out;
   logic signed [SB:0]     lp_diff;
   logic signed [SB+16:0]  lp_prod;
   logic signed [63:0]     lp_tot, lp_sat;
   logic signed [SB-1:0]   lp_new;
   always_comb begin
      c_out   = $signed(c_rdata);
      lp_diff = (SB+1)'(lp_ff[line_ff]) - (SB+1)'(c_out);
      lp_prod = lp_diff * $signed({1'b0, damping});
      lp_tot  = (64'(c_out) <<< 15) + 64'(lp_prod) + 64'sd16384;
      lp_sat  = sat_to(lp_tot >>> 15, SB);
      lp_new  = lp_sat[SB-1:0];
   end

   // comb store: sat(x + round(lp * fb / 2^15))
   logic signed [SB+15:0]  fb_prod;
   logic signed [63:0]     fb_tot;
   always_comb begin
      fb_prod = lp_ff[line_ff] * $signed({1'b0, fb_value});
      fb_tot  = sat_to(64'(x_ff) + ((64'(fb_prod) + 64'sd16384) >>> 15), SB);
   end

   // allpass: store sat(x + round(out / 2)), pass out - x
   logic signed [SB-1:0]   a_out;
   logic signed [CW-1:0]   ap_x, ap_y;
   logic                   ap_left;
   logic signed [63:0]     ap_tot;
   always_comb begin
      a_out   = $signed(a_rdata);
      ap_left = 32'(ap_line_ff) < ALLPASS_COUNT;
      ap_x    = ap_left ? sl_ff : sr_ff;
      ap_tot  = sat_to(64'(ap_x) + ((64'(a_out) + 64'sd1) >>> 1), SB);
      ap_y    = CW'(a_out) - ap_x;
   end

   // output mix, one product per step
   logic signed [AW-1:0]   m_a;
   logic [14:0]            m_b;
   logic                   m_wet, m_first, m_end;
   logic signed [AW+15:0]  m_prod;
   logic signed [MW-1:0]   m_term, m_acc;
   logic signed [63:0]     m_sat;
   always_comb begin
      unique case (mix_ff)
         3'd0:    begin m_a = AW'(sl_ff);  m_b = wet_main_gain;  end
         3'd1:    begin m_a = AW'(sr_ff);  m_b = wet_cross_gain; end
         3'd2:    begin m_a = AW'(inl_ff); m_b = dry_gain;       end
         3'd3:    begin m_a = AW'(sr_ff);  m_b = wet_main_gain;  end
         3'd4:    begin m_a = AW'(sl_ff);  m_b = wet_cross_gain; end
         default: begin m_a = AW'(inr_ff); m_b = dry_gain;       end
      endcase
      m_wet   = (mix_ff != 3'd2) && (mix_ff != 3'd5);
      m_first = (mix_ff == 3'd0) || (mix_ff == 3'd3);
      m_end   = (mix_ff == 3'd2) || (mix_ff == 3'd5);
      m_prod  = m_a * $signed({1'b0, m_b});
      m_term  = m_wet ? (MW'(m_prod) <<< 2) : MW'(m_prod);
      m_acc   = (m_first ? '0 : acc_ff) + m_term;
      m_sat   = sat_to((64'(m_acc) + 64'sd16384) >>> 15, 16);
   end

   // memory port muxing
   always_comb begin
      c_we    = 1'b0;
      a_we    = 1'b0;
      c_waddr = {line_ff, cp_eff};
      c_raddr = {line_ff, cp_eff};
      a_waddr = {ap_line_ff, ap_eff};
      a_raddr = {ap_line_ff, ap_eff};
      c_wdata = fb_tot[SB-1:0];
      a_wdata = ap_tot[SB-1:0];
      unique case (cmd.op)
         OP_CLEAR: begin
            c_we    = 1'b1;
            a_we    = 1'b1;
            c_waddr = clr_ff[CAW-1:0];
            a_waddr = clr_ff[AAW-1:0];
            c_wdata = '0;
            a_wdata = '0;
         end
         OP_COMB_FB: c_we = 1'b1;
         OP_AP_WR:   a_we = 1'b1;
         default: ;
      endcase
   end

   // control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= '0;
         ap_line_ff <= '0;
         mix_ff     <= '0;
         clr_ff     <= '0;
         for (int i = 0; i < NCL; i++) begin
            cpos_ff[i] <= '0;
            lp_ff[i]   <= '0;
         end
         for (int i = 0; i < NAL; i++) begin
            apos_ff[i] <= '0;
         end
      end else begin
         unique case (cmd.op)
            OP_CLEAR: begin
               if (!clr_ff[CLRW]) begin
                  clr_ff <= clr_ff + (CLRW+1)'(1);
               end
            end
            OP_LOAD: begin
               line_ff    <= '0;
               ap_line_ff <= '0;
               mix_ff     <= '0;
            end
            OP_COMB_LP: lp_ff[line_ff] <= lp_new;
            OP_COMB_FB: begin
               cpos_ff[line_ff] <= cp_next;
               line_ff          <= line_ff + CLW'(1);
            end
            OP_AP_WR: begin
               apos_ff[ap_line_ff] <= ap_next;
               ap_line_ff          <= ap_line_ff + ALW'(1);
            end
            OP_MIX: mix_ff <= mix_ff + 3'd1;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            inl_ff <= left_in;
            inr_ff <= rsel;
            x_ff   <= 17'((28'(x_prod) + 28'sd16384) >>> 15);
            sl_ff  <= '0;
            sr_ff  <= '0;
         end
         OP_COMB_LP: begin
            if (32'(line_ff) < COMB_COUNT) begin
               sl_ff <= sl_ff + CW'(c_out);
            end else begin
               sr_ff <= sr_ff + CW'(c_out);
            end
         end
         OP_AP_WR: begin
            if (ap_left) begin
               sl_ff <= ap_y;
            end else begin
               sr_ff <= ap_y;
            end
         end
         OP_MIX: begin
            acc_ff <= m_acc;
            if (mix_ff == 3'd2) begin
               ol_ff <= m_sat[15:0];
            end
            if (mix_ff == 3'd5) begin
               or_ff <= mono_input ? ol_ff : m_sat[15:0];
            end
         end
         OP_OUT: begin
            lo_ff <= ol_ff;
            ro_ff <= or_ff;
         end
         OP_BYPASS: begin
            lo_ff <= inl_ff;
            ro_ff <= inr_ff;
         end
         default: ;
      endcase
   end

   assign fb_line           = line_ff;
   assign status.clear_done = clr_ff[CLRW];
   assign status.comb_last  = (line_ff == CLW'(NCL - 1));
   assign status.ap_last    = (ap_line_ff == ALW'(NAL - 1));
   assign status.mix_last   = m_end && (mix_ff == 3'd5);
   assign left_out          = lo_ff;
   assign right_out         = ro_ff;
endmodule

>>> hw/rtl/scar_ctrl.sv
// sequencer of the reverb: clear sweep, line walk, mix, bypass and output beat
// depends on scar_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "stereo_comb_allpass_reverb_macros.svh"
module scar_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 enable,
   input  scar_pkg::status_type status,
   output scar_pkg::cmd_type    cmd
);
   import scar_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;

   assign slot_free = !valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:    if (req_tvalid) state_in = enable ? ST_COMB_RD : ST_BYPASS;
         ST_BYPASS:  if (slot_free) state_in = ST_IDLE;
         ST_COMB_RD: state_in = ST_COMB_LP;
         ST_COMB_LP: state_in = ST_COMB_FB;
         ST_COMB_FB: state_in = status.comb_last ? ST_AP_RD : ST_COMB_RD;
         ST_AP_RD:   state_in = ST_AP_WR;
         ST_AP_WR:   state_in = status.ap_last ? ST_MIX : ST_AP_RD;
         ST_MIX:     if (status.mix_last) state_in = ST_DONE;
         ST_DONE:    if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:   cmd.op = OP_CLEAR;
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         ST_BYPASS:  if (slot_free) cmd.op = OP_BYPASS;
         ST_COMB_RD: cmd.op = OP_COMB_RD;
         ST_COMB_LP: cmd.op = OP_COMB_LP;
         ST_COMB_FB: cmd.op = OP_COMB_FB;
         ST_AP_RD:   cmd.op = OP_AP_RD;
         ST_AP_WR:   cmd.op = OP_AP_WR;
         ST_MIX:     cmd.op = OP_MIX;
         ST_DONE:    if (slot_free) cmd.op = OP_OUT;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // result beat holding register
   always_comb begin
      if (cmd.op == OP_OUT || cmd.op == OP_BYPASS) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   `SCAR_ASSERT_NR(a_reset_clears, clock, reset |=> (state_ff == ST_CLEAR))
   `SCAR_ASSERT(a_accept_leaves_idle, clock, reset, (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
   `SCAR_ASSERT(a_beat_held, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
   `SCAR_ASSERT(a_beat_source, clock, reset, $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DONE || $past(state_ff) == ST_BYPASS))
endmodule

>>> hw/rtl/stereo_comb_allpass_reverb.sv
// Stereo comb/allpass reverb. After reset the block sweeps both delay memories to zero,
// one address per cycle, and takes no sample until then; register writes are taken
// throughout. With reverb enabled each sample pair walks every comb line through its
// read, lowpass and write-back states on the comb memory, then every allpass line
// through its read and write states, then the mix steps. A new pair is taken while
// the previous result still waits on the output.
// depends on scar_pkg, scar_csr, scar_ctrl, scar_datapath
`timescale 1ns / 1ps
module stereo_comb_allpass_reverb #(
   parameter int COMB_COUNT         = scar_pkg::COMB_COUNT_DEF,
   parameter int ALLPASS_COUNT      = scar_pkg::ALLPASS_COUNT_DEF,
   parameter int STEREO_SPREAD      = scar_pkg::STEREO_SPREAD_DEF,
   parameter int COMB_MAX_LENGTH    = scar_pkg::COMB_MAX_LENGTH_DEF,
   parameter int ALLPASS_MAX_LENGTH = scar_pkg::ALLPASS_MAX_LENGTH_DEF,
   parameter int SAMPLE_BITS        = scar_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // left_in, right_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // left_out, right_out
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scar_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scar_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scar_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import scar_pkg::*;

   logic                            enable, mono_input;
   logic [14:0]                     dry_gain, wet_main_gain, wet_cross_gain, damping;
   logic [$clog2(2*COMB_COUNT)-1:0] fb_line;
   logic [14:0]                     fb_value;
   cmd_type                         cmd;
   status_type                      status;
   logic signed [15:0]              left_out, right_out;

   scar_csr #(.COMB_COUNT(COMB_COUNT)) u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .enable(enable), .mono_input(mono_input), .dry_gain(dry_gain),
      .wet_main_gain(wet_main_gain), .wet_cross_gain(wet_cross_gain),
      .damping(damping), .fb_line(fb_line), .fb_value(fb_value)
   );

   scar_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .enable(enable), .status(status), .cmd(cmd)
   );

   scar_datapath #(
      .COMB_COUNT(COMB_COUNT), .ALLPASS_COUNT(ALLPASS_COUNT),
      .STEREO_SPREAD(STEREO_SPREAD), .COMB_MAX_LENGTH(COMB_MAX_LENGTH),
      .ALLPASS_MAX_LENGTH(ALLPASS_MAX_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .left_in(req_tdata[15:0]), .right_in(req_tdata[31:16]),
      .mono_input(mono_input), .dry_gain(dry_gain),
      .wet_main_gain(wet_main_gain), .wet_cross_gain(wet_cross_gain),
      .damping(damping), .fb_line(fb_line), .fb_value(fb_value),
      .left_out(left_out), .right_out(right_out)
   );

   assign rsp_tdata = {right_out, left_out};
endmodule
